### sv/stnk_pkg.sv
// Shared constants, codes and types for the sorted key table core.
// No dependencies; every other file but stnk_ram imports this package.
package stnk_pkg;

	localparam int CAPACITY      = 64;
	localparam int MAX_NEIGHBORS = 16;

	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int NB_W      = $clog2(MAX_NEIGHBORS + 1);
	localparam int KEY_W     = 32;
	localparam int HANDLE_W  = 16;
	localparam int DIST_W    = 32;
	localparam int MCNT_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int STATUS_W  = 2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT    = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NEIGHBOR = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

	localparam logic [DIST_W-1:0] MAX_DIST_RESET  = '1;
	localparam logic [MCNT_W-1:0] MAX_COUNT_RESET = 5'd1;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [HANDLE_W-1:0]     handle;
	} entry_t;

	// Absolute difference of two signed keys; always fits DIST_W bits.
	function automatic logic [DIST_W-1:0] key_dist(input logic signed [KEY_W-1:0] a,
			input logic signed [KEY_W-1:0] b);
		logic signed [KEY_W:0] d;
		logic signed [KEY_W:0] n;
		d = {a[KEY_W-1], a} - {b[KEY_W-1], b};
		n = -d;
		return d[KEY_W] ? n[DIST_W-1:0] : d[DIST_W-1:0];
	endfunction

endpackage

### sv/stnk_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module stnk_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/sorted_table_nearest_keys_core.sv
// Sorted key table with 1-D nearest-neighbor query; uses stnk_pkg and stnk_ram.
// Insert: read the top entry, move each entry at or above the new key up by one,
// walking down, then write the new entry; an empty table is written directly and a
// full table is rejected. Query: binary search by halving, load both neighbors, then
// reload one candidate per reported neighbor. One item at a time; the entry RAM
// sets the pace. Reset: entry count zero, registers to reset values, RAM left as is.
module sorted_table_nearest_keys_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic signed [stnk_pkg::KEY_W-1:0] key,
	input  logic [stnk_pkg::HANDLE_W-1:0]    handle,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [stnk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stnk_pkg::DIST_W-1:0]      cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [stnk_pkg::STATUS_W-1:0]    status,
	output logic [stnk_pkg::HANDLE_W-1:0]    neighbor_handle,
	output logic [stnk_pkg::DIST_W-1:0]      distance,
	output logic                             last
);
	import stnk_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,   // read the top entry, or write directly into an empty table
		S_INS_CMP,  // shift entries at or above the key up by one, walking down
		S_INS_PUT,  // every entry moved: new entry goes to slot zero
		S_SR_RD,    // binary search: issue read of the midpoint
		S_SR_CMP,   // binary search: narrow the range
		S_WK_RDU,   // reload the upper candidate
		S_WK_GTU,
		S_WK_RDD,   // reload the lower candidate
		S_WK_GTD,
		S_WK_DEC,   // pick the closer side, emit the held result
		S_DONE      // single insert result
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [DIST_W-1:0]        max_dist_q;
	logic [MCNT_W-1:0]        max_count_q;
	logic signed [KEY_W-1:0]  key_q;
	logic [HANDLE_W-1:0]      handle_q;
	logic [IDX_W-1:0]         idx_q;
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic [IDX_W-1:0]         mid_q;
	logic [CNT_W-1:0]         up_q;
	logic [CNT_W-1:0]         dn_q;
	logic [DIST_W-1:0]        du_q;
	logic [DIST_W-1:0]        dd_q;
	logic [HANDLE_W-1:0]      uph_q;
	logic [HANDLE_W-1:0]      dnh_q;
	logic                     init_q;
	logic [NB_W-1:0]          n_q;
	logic [NB_W-1:0]          limit_q;
	logic                     hold_valid_q;
	logic [HANDLE_W-1:0]      hold_h_q;
	logic [DIST_W-1:0]        hold_d_q;
	logic [STATUS_W-1:0]      resp_q;
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic [HANDLE_W-1:0]      nh_q;
	logic [DIST_W-1:0]        dist_q;
	logic                     last_q;

	// Entry RAM port
	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	entry_t                   ram_wdata;
	logic [IDX_W-1:0]         ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t                   rd_entry;
	entry_t                   new_entry;

	logic [CNT_W:0]           mid_sum;
	logic [IDX_W-1:0]         mid;
	logic [CNT_W-1:0]         cnt_m1;
	logic [CNT_W-1:0]         dn_m1;
	logic                     out_free;
	logic                     up_ok;
	logic                     dn_ok;
	logic                     take_dn;
	logic [DIST_W-1:0]        pick_d;
	logic [HANDLE_W-1:0]      pick_h;
	logic                     walk_end;
	logic                     dec_go;
	logic                     shift_up;

	assign rd_entry  = entry_t'(ram_rdata);
	assign new_entry = '{key: key_q, handle: handle_q};
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[IDX_W:1];
	assign cnt_m1    = count_q - CNT_W'(1);
	assign dn_m1     = dn_q - CNT_W'(1);
	assign out_free  = !out_valid_q || out_ready;

	// Lower side wins on a tie; stop on count, both ends, or distance limit.
	assign up_ok    = up_q < count_q;
	assign dn_ok    = dn_q != '0;
	assign take_dn  = dn_ok && (!up_ok || dd_q <= du_q);
	assign pick_d   = take_dn ? dd_q : du_q;
	assign pick_h   = take_dn ? dnh_q : uph_q;
	assign walk_end = (n_q == limit_q) || (!up_ok && !dn_ok) || (pick_d > max_dist_q);
	// Results are held back one step so that the final one can carry last.
	assign dec_go   = out_free || !(walk_end || hold_valid_q);
	assign shift_up = rd_entry.key >= key_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q + IDX_W'(1);
		ram_wdata = new_entry;
		ram_raddr = up_q[IDX_W-1:0];
		unique case (state_q)
			S_INS_RD: begin
				if (count_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
				end
				ram_raddr = cnt_m1[IDX_W-1:0];
			end
			S_INS_CMP: begin
				ram_we    = 1'b1;
				ram_raddr = idx_q - IDX_W'(1);
				if (shift_up) begin
					ram_wdata = rd_entry;
				end
			end
			S_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
			end
			S_SR_RD: begin
				ram_raddr = (lo_q < hi_q) ? mid : lo_q[IDX_W-1:0];
			end
			S_WK_GTU, S_WK_RDD: begin
				ram_raddr = dn_m1[IDX_W-1:0];
			end
			default: begin
				ram_raddr = up_q[IDX_W-1:0];
			end
		endcase
	end

	stnk_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			max_dist_q   <= MAX_DIST_RESET;
			max_count_q  <= MAX_COUNT_RESET;
			key_q        <= '0;
			handle_q     <= '0;
			idx_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			up_q         <= '0;
			dn_q         <= '0;
			du_q         <= '0;
			dd_q         <= '0;
			uph_q        <= '0;
			dnh_q        <= '0;
			init_q       <= 1'b0;
			n_q          <= '0;
			limit_q      <= '0;
			hold_valid_q <= 1'b0;
			hold_h_q     <= '0;
			hold_d_q     <= '0;
			resp_q       <= ST_INSERTED;
			out_valid_q  <= 1'b0;
			status_q     <= ST_INSERTED;
			nh_q         <= '0;
			dist_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			// Configuration is to be written only while idle; the user must ensure this, the block itself does not enforce it
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MAX_DISTANCE: max_dist_q  <= cfg_data;
					REG_MAX_COUNT:    max_count_q <= cfg_data[MCNT_W-1:0];
				endcase
			end

			// Drop the output item once taken; a new one below overrides
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q    <= key;
						handle_q <= handle;
						if (action == ACT_QUERY) begin
							lo_q         <= '0;
							hi_q         <= count_q;
							n_q          <= '0;
							hold_valid_q <= 1'b0;
							if (int'(max_count_q) > MAX_NEIGHBORS) begin
								limit_q <= NB_W'(MAX_NEIGHBORS);
							end else begin
								limit_q <= NB_W'(max_count_q);
							end
							state_q <= S_SR_RD;
						end else if (count_q >= CNT_W'(CAPACITY)) begin
							resp_q  <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							resp_q  <= ST_INSERTED;
							state_q <= S_INS_RD;
						end
					end
				end
				S_INS_RD: begin
					if (count_q == '0) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						idx_q   <= cnt_m1[IDX_W-1:0];
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (!shift_up) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end else if (idx_q == '0) begin
						state_q <= S_INS_PUT;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_SR_RD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_SR_CMP;
					end else begin
						// Start point found; read of the upper entry already issued
						up_q    <= lo_q;
						dn_q    <= lo_q;
						init_q  <= 1'b1;
						state_q <= S_WK_GTU;
					end
				end
				S_SR_CMP: begin
					if (rd_entry.key < key_q) begin
						lo_q <= CNT_W'(mid_q) + CNT_W'(1);
					end else begin
						hi_q <= CNT_W'(mid_q);
					end
					state_q <= S_SR_RD;
				end
				S_WK_RDU: begin
					state_q <= S_WK_GTU;
				end
				S_WK_GTU: begin
					du_q  <= key_dist(rd_entry.key, key_q);
					uph_q <= rd_entry.handle;
					if (init_q) begin
						init_q  <= 1'b0;
						state_q <= S_WK_GTD;
					end else begin
						state_q <= S_WK_DEC;
					end
				end
				S_WK_RDD: begin
					state_q <= S_WK_GTD;
				end
				S_WK_GTD: begin
					dd_q    <= key_dist(rd_entry.key, key_q);
					dnh_q   <= rd_entry.handle;
					state_q <= S_WK_DEC;
				end
				S_WK_DEC: begin
					if (dec_go) begin
						if (walk_end) begin
							out_valid_q <= 1'b1;
							last_q      <= 1'b1;
							if (hold_valid_q) begin
								status_q <= ST_NEIGHBOR;
								nh_q     <= hold_h_q;
								dist_q   <= hold_d_q;
							end else begin
								status_q <= ST_NONE;
								nh_q     <= '0;
								dist_q   <= '0;
							end
							state_q <= S_IDLE;
						end else begin
							if (hold_valid_q) begin
								out_valid_q <= 1'b1;
								status_q    <= ST_NEIGHBOR;
								nh_q        <= hold_h_q;
								dist_q      <= hold_d_q;
								last_q      <= 1'b0;
							end
							hold_valid_q <= 1'b1;
							hold_h_q     <= pick_h;
							hold_d_q     <= pick_d;
							n_q          <= n_q + NB_W'(1);
							if (take_dn) begin
								dn_q    <= dn_m1;
								state_q <= S_WK_RDD;
							end else begin
								up_q    <= up_q + CNT_W'(1);
								state_q <= S_WK_RDU;
							end
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= resp_q;
						nh_q        <= '0;
						dist_q      <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready        = state_q == S_IDLE;
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign neighbor_handle = nh_q;
	assign distance        = dist_q;
	assign last            = last_q;

endmodule

### sv/stnk_checker.sv
// Port-level assertions for sorted_table_nearest_keys_core, bound to the top level.
// Depends on stnk_pkg.
module stnk_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [stnk_pkg::STATUS_W-1:0]    status,
	input logic [stnk_pkg::HANDLE_W-1:0]    neighbor_handle,
	input logic [stnk_pkg::DIST_W-1:0]      distance,
	input logic                             last
);
	import stnk_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(neighbor_handle) && $stable(distance) && $stable(last))
		else $error("output item changed while stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_NEIGHBOR |-> last)
		else $error("insert or no-neighbor item not marked last");

	a_single_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_NEIGHBOR |-> neighbor_handle == '0 && distance == '0)
		else $error("non-neighbor item carries handle or distance");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

endmodule

bind sorted_table_nearest_keys_core stnk_checker u_stnk_checker (.*);

### tb/sv/sorted_table_nearest_keys_core_tb.sv
// Self-checking bench for sorted_table_nearest_keys_core: inserts and nearest-key queries
// are checked against an in-bench table predictor under several register settings.
// Depends on stnk_pkg and the core RTL only.
module sorted_table_nearest_keys_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stnk_pkg::*;

	localparam logic signed [KEY_W-1:0] KEY_MIN  = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [KEY_W-1:0] KEY_UNIT = 32'sh0001_0000;
	localparam logic [DIST_W-1:0] DIST_ANY = '1;

	typedef struct {
		logic                    action;
		logic signed [KEY_W-1:0] key;
		logic [HANDLE_W-1:0]     handle;
	} table_op_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle;
		logic [DIST_W-1:0]   gap;
		logic                last;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    action = ACT_INSERT;
	logic signed [KEY_W-1:0] key = '0;
	logic [HANDLE_W-1:0]     handle = '0;

	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_MAX_DISTANCE;
	logic [DIST_W-1:0]       cfg_data = '0;

	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [STATUS_W-1:0]     status;
	logic [HANDLE_W-1:0]     neighbor_handle;
	logic [DIST_W-1:0]       distance;
	logic                    last;

	// Predictor state: the sorted table and our copy of the two registers.
	logic signed [KEY_W-1:0] tbl_keys[$];
	logic [HANDLE_W-1:0]     tbl_handles[$];
	logic [DIST_W-1:0]       cfg_max_dist = MAX_DIST_RESET;
	logic [MCNT_W-1:0]       cfg_max_count = MAX_COUNT_RESET;

	table_op_t ops_to_send[$];    // items waiting for the driver
	reply_t    table_replies[$];  // replies predicted but not yet seen
	table_op_t next_op;
	reply_t    seen_reply;
	int        errors = 0;
	int        idle_pct = 16;

	sorted_table_nearest_keys_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.key             (key),
		.handle          (handle),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.neighbor_handle (neighbor_handle),
		.distance        (distance),
		.last            (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop in case the core hangs.
	initial begin
		#4ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Exact absolute key difference, done in 64 bits so the extremes cannot wrap.
	function automatic logic [DIST_W-1:0] key_gap(input logic signed [KEY_W-1:0] a,
			input logic signed [KEY_W-1:0] b);
		longint diff;
		diff = longint'(a) - longint'(b);
		if (diff < 0)
			diff = -diff;
		return diff[DIST_W-1:0];
	endfunction

	// Apply one accepted item to the predicted table and queue the replies it causes.
	task automatic table_access(input logic act, input logic signed [KEY_W-1:0] k,
			input logic [HANDLE_W-1:0] h);
		int unsigned       pos;
		int unsigned       up;
		int unsigned       down;
		int unsigned       limit;
		bit                up_ok;
		bit                down_ok;
		bit                take_down;
		logic [DIST_W-1:0] du;
		logic [DIST_W-1:0] dd;
		logic [DIST_W-1:0] d;
		reply_t            r;
		reply_t            found[$];

		// Lower bound: first stored key not below k.
		pos = 0;
		while (pos < tbl_keys.size() && tbl_keys[pos] < k)
			pos++;

		if (act == ACT_INSERT) begin
			r = '{status: ST_INSERTED, handle: '0, gap: '0, last: 1'b1};
			if (tbl_keys.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				tbl_keys.insert(pos, k);
				tbl_handles.insert(pos, h);
			end
			table_replies.insert(table_replies.size(), r);
			return;
		end

		// Query: walk outward from the lower bound, nearer side first, lower side on a tie.
		limit = (cfg_max_count > MAX_NEIGHBORS) ? MAX_NEIGHBORS : cfg_max_count;
		up = pos;
		down = pos;
		while (found.size() < limit) begin
			up_ok = up < tbl_keys.size();
			down_ok = down > 0;
			if (!up_ok && !down_ok)
				break;
			du = up_ok ? key_gap(tbl_keys[up], k) : '0;
			dd = down_ok ? key_gap(tbl_keys[down - 1], k) : '0;
			take_down = down_ok && (!up_ok || dd <= du);
			d = take_down ? dd : du;
			if (d > cfg_max_dist)
				break;
			r = '{status: ST_NEIGHBOR, handle: '0, gap: d, last: 1'b0};
			if (take_down) begin
				down--;
				r.handle = tbl_handles[down];
			end else begin
				r.handle = tbl_handles[up];
				up++;
			end
			found.insert(found.size(), r);
		end

		if (found.size() == 0) begin
			r = '{status: ST_NONE, handle: '0, gap: '0, last: 1'b1};
			table_replies.insert(table_replies.size(), r);
		end else begin
			found[found.size() - 1].last = 1'b1;
			foreach (found[i])
				table_replies.insert(table_replies.size(), found[i]);
		end
	endtask

	// Driver: predict on acceptance, hold the payload until taken, idle at random otherwise.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				table_access(action, key, handle);
			if (!in_valid || in_ready) begin
				if (ops_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_op = ops_to_send.pop_front();
					in_valid <= 1'b1;
					action <= next_op.action;
					key <= next_op.key;
					handle <= next_op.handle;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each reply against the oldest prediction, stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (table_replies.size() == 0) begin
					errors++;
					$display("%0t: reply with nothing expected: status %0d handle %h dist %h last %b",
						$time, status, neighbor_handle, distance, last);
				end else begin
					seen_reply = table_replies.pop_front();
					if (status !== seen_reply.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, seen_reply.status, status);
					end
					if (neighbor_handle !== seen_reply.handle) begin
						errors++;
						$display("%0t: neighbor_handle expected %h actual %h",
							$time, seen_reply.handle, neighbor_handle);
					end
					if (distance !== seen_reply.gap) begin
						errors++;
						$display("%0t: distance expected %h actual %h",
							$time, seen_reply.gap, distance);
					end
					if (last !== seen_reply.last) begin
						errors++;
						$display("%0t: last expected %b actual %b",
							$time, seen_reply.last, last);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic queue_op(input logic act, input logic signed [KEY_W-1:0] k,
			input logic [HANDLE_W-1:0] h);
		table_op_t op;
		op = '{action: act, key: k, handle: h};
		ops_to_send.insert(ops_to_send.size(), op);
	endtask

	// Advance until every queued item is taken and every predicted reply has come back.
	task automatic wait_replies_drained();
		do
			@(negedge clk);
		while (ops_to_send.size() != 0 || in_valid || table_replies.size() != 0);
	endtask

	// Register write; only called while the core is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MAX_DISTANCE)
			cfg_max_dist = data;
		else
			cfg_max_count = data[MCNT_W-1:0];
	endtask

	// Keys bunched on whole units (duplicates, ties), tiny raw values, extremes, or anything.
	function automatic logic signed [KEY_W-1:0] draw_key();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 35)
			return (int'($urandom_range(16)) - 8) * 65536;
		if (sel < 55)
			return int'($urandom_range(128)) - 64;
		if (sel < 65) begin
			case ($urandom_range(5))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return KEY_MIN + 1;
				3: return KEY_MAX - 1;
				4: return -1;
				default: return '0;
			endcase
		end
		return $urandom;
	endfunction

	// One setting: write both registers, run random traffic, drain.
	task automatic run_phase(input logic [DIST_W-1:0] gap_limit,
			input logic [DIST_W-1:0] count, input int n_items, input int idle);
		write_reg(REG_MAX_DISTANCE, gap_limit);
		write_reg(REG_MAX_COUNT, count);
		idle_pct = idle;
		repeat (n_items)
			queue_op(($urandom_range(99) < 45) ? ACT_INSERT : ACT_QUERY, draw_key(),
				$urandom_range(65535));
		wait_replies_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one neighbor, unlimited distance.
		queue_op(ACT_QUERY, '0, 16'h5A5A);                 // empty table gives none
		queue_op(ACT_QUERY, KEY_MIN, 16'hFFFF);
		queue_op(ACT_INSERT, KEY_MIN, 16'h0000);
		queue_op(ACT_INSERT, KEY_MAX, 16'hFFFF);
		queue_op(ACT_QUERY, '0, 16'h0000);                  // upper side is nearer
		queue_op(ACT_QUERY, -1, 16'h0000);                  // lower side is nearer
		queue_op(ACT_INSERT, KEY_UNIT, 16'h1234);
		queue_op(ACT_INSERT, 3 * KEY_UNIT, 16'h5678);
		queue_op(ACT_QUERY, 2 * KEY_UNIT, 16'h0000);        // tie goes to the lower side
		queue_op(ACT_INSERT, KEY_UNIT, 16'hAAAA);           // lands before the equal key
		queue_op(ACT_QUERY, KEY_MAX, 16'h0000);
		queue_op(ACT_QUERY, KEY_MIN, 16'h0000);
		wait_replies_drained();

		// Full count: whole table in distance order, widest possible distance.
		write_reg(REG_MAX_COUNT, 32'd16);
		queue_op(ACT_QUERY, 2 * KEY_UNIT, 16'h0000);
		queue_op(ACT_QUERY, KEY_MAX, 16'h0000);
		queue_op(ACT_QUERY, KEY_MIN + 1, 16'h0000);
		wait_replies_drained();

		// Exact matches only, count above the neighbor limit saturates.
		write_reg(REG_MAX_DISTANCE, 32'd0);
		write_reg(REG_MAX_COUNT, 32'd31);
		queue_op(ACT_QUERY, KEY_UNIT, 16'h0000);
		queue_op(ACT_QUERY, 2 * KEY_UNIT, 16'h0000);        // nothing in reach
		wait_replies_drained();

		// Distance equal to the limit still passes.
		write_reg(REG_MAX_DISTANCE, 32'h0001_0000);
		queue_op(ACT_QUERY, 2 * KEY_UNIT, 16'h0000);
		wait_replies_drained();

		// Zero count reports none.
		write_reg(REG_MAX_COUNT, 32'd0);
		queue_op(ACT_QUERY, KEY_UNIT, 16'h0000);
		wait_replies_drained();

		// Random traffic; the table fills to capacity and later inserts are rejected.
		run_phase(DIST_ANY, 32'd1, 50, 16);
		run_phase(DIST_ANY, 32'd16, 50, 0);                 // no idling on either side
		run_phase(32'h0008_0000, 32'd16, 50, 16);
		run_phase($urandom, $urandom_range(1, 16), 50, 16);
		run_phase(32'd0, 32'd16, 50, 16);
		run_phase(DIST_ANY, 32'd5, 50, 16);
		run_phase(32'h7FFF_FFFF, 32'd16, 50, 16);

		// Let any stray reply surface before the verdict.
		repeat (100) @(posedge clk);
		if (errors == 0 && table_replies.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
sv/stnk_pkg.sv
sv/stnk_ram.sv
sv/sorted_table_nearest_keys_core.sv
sv/stnk_checker.sv
tb/sv/sorted_table_nearest_keys_core_tb.sv
